// File: rtl/cbm_pkg.sv
// Shared types and constants of the console bank mapper.
`default_nettype none

package cbm_pkg;

	// Request commands
	localparam logic [1:0] CMD_MEM_READ  = 2'd0;
	localparam logic [1:0] CMD_MEM_WRITE = 2'd1;
	localparam logic [1:0] CMD_PORT_WR   = 2'd2;

	// Configuration register indexes (word address bit 2)
	localparam logic REG_BANK_MASK = 1'b0;
	localparam logic REG_LEGACY    = 1'b1;

	// Address map
	localparam logic [15:0] RAM_BASE     = 16'hC000;
	localparam logic [15:0] FIXED_LIMIT  = 16'h0400;
	localparam logic [15:0] LEGACY_LIMIT = 16'h2000;
	localparam logic [15:0] CTRL_CART    = 16'hFFFC;
	localparam logic [15:0] CTRL_SLOT1   = 16'hFFFD;
	localparam logic [15:0] CTRL_SLOT2   = 16'hFFFE;
	localparam logic [15:0] CTRL_SLOT3   = 16'hFFFF;
	localparam logic [7:0]  PORT_MAPPER  = 8'h3E;

	// Slot index (address bits 15:14)
	localparam logic [1:0] SLOT_1 = 2'd0;
	localparam logic [1:0] SLOT_2 = 2'd1;

	localparam logic [7:0] BANK_MASK_RST = 8'd31;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  data;
	} cbm_req_t;

	typedef struct packed {
		logic        from_rom;
		logic [21:0] rom_address;
		logic [7:0]  ram_data;
	} cbm_rsp_t;

endpackage

`default_nettype wire

// File: rtl/console_bank_mapper.sv
// Top level of the console bank mapper: ROM paging, work RAM and control registers.
//
// Usage:
//   The CPU side presents one request per cycle on req (command, address, data)
//   with req_valid; it is taken at a rising edge where req_valid is high and
//   req_stall is low. Every request yields exactly one response on rsp, taken
//   at an edge where rsp_valid is high and rsp_stall is low. Reads below 0xC000
//   return a translated ROM byte address; reads at 0xC000 and above return the
//   mirrored work RAM byte; writes and port writes return an all-zero response.
//   Path: input register, index and map stage, then the response register that
//   also holds the RAM read data; rsp_valid follows the request through them.
//   Throughput: one request per cycle while req_stall is low; the work RAM
//   serves one read or one write per cycle in the map stage.
//   Reset: page registers return to 0/1/2, cart RAM flag to 0, bank mask to 31,
//   legacy_mode to 0; then a clearing pass writes zero to all RAM_BYTES work
//   RAM entries, one per cycle, with req_stall high (APB writes still taken).
//   When the receiver stalls, the whole pipeline holds and req_stall rises in
//   the same cycle, so no response is lost or repeated.
//   Configuration is written over APB: bank mask at 0x0, legacy_mode at 0x4.
`default_nettype none

module console_bank_mapper
	import cbm_pkg::*;
#(
	parameter int RAM_BYTES = 8192,
	parameter int PAGE_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	// request channel
	input  wire logic        req_valid,
	output      logic        req_stall,
	input  wire cbm_req_t    req,
	// response channel
	output      logic        rsp_valid,
	input  wire logic        rsp_stall,
	output      cbm_rsp_t    rsp
);

	// RAM index geometry; address mod RAM_BYTES is done by a reciprocal multiply
	localparam int AW = $clog2(RAM_BYTES);
	localparam int QMAX = 65535 / RAM_BYTES;
	localparam int QW = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
	localparam longint unsigned RECIP = ((64'd1 << 32) + RAM_BYTES - 1) / RAM_BYTES;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = 16 + RW;

	// Configuration registers
	logic [7:0] bank_mask_q;
	logic       legacy_q;

	// Mapper state
	logic [PAGE_BITS-1:0] slot1_page_q;
	logic [PAGE_BITS-1:0] slot2_page_q;
	logic [PAGE_BITS-1:0] slot3_page_q;
	logic                 cart_ram_q;

	// Clearing pass
	logic          clr_active_q;
	logic [AW-1:0] clr_idx_q;

	// Pipeline
	logic        advance;
	logic        v_s1, v_s2, v_s3;
	logic [1:0]  cmd_s1, cmd_s2;
	logic [15:0] addr_s1, addr_s2;
	logic [7:0]  data_s1, data_s2;
	logic [QW-1:0] quo_s2;
	logic        from_rom_s3;
	logic        ram_sel_s3;
	logic [21:0] rom_addr_s3;

	// Work RAM
	logic [7:0]    work_ram [RAM_BYTES];
	logic [7:0]    ram_rd_q;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;

	//------------------------------------------------------------------
	// Configuration port
	//------------------------------------------------------------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_mask_q <= BANK_MASK_RST;
			legacy_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BANK_MASK: bank_mask_q <= pwdata[7:0];
				REG_LEGACY:    legacy_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BANK_MASK: prdata = {24'd0, bank_mask_q};
			REG_LEGACY:    prdata = {31'd0, legacy_q};
			default:       prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Handshake: all stages move together; hold while the response is stalled
	//------------------------------------------------------------------
	assign advance   = !(v_s3 && rsp_stall);
	assign req_stall = clr_active_q || !advance;
	assign rsp_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= req_valid && !req_stall;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	//------------------------------------------------------------------
	// Stage 1: input register, quotient of address by RAM_BYTES
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1  <= req.command;
			addr_s1 <= req.address;
			data_s1 <= req.data;
		end
	end

	logic [PW-1:0] quo_prod;
	assign quo_prod = PW'(addr_s1) * PW'(RW'(RECIP));

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2  <= cmd_s1;
			addr_s2 <= addr_s1;
			data_s2 <= data_s1;
			quo_s2  <= quo_prod[32 +: QW];
		end
	end

	//------------------------------------------------------------------
	// Stage 2: RAM index, address translation, RAM access, register updates
	//------------------------------------------------------------------
	logic [16:0]          quo_times_n;
	logic [16:0]          rem_full;
	logic [AW-1:0]        ram_idx;
	logic                 is_ram;
	logic                 do_read, do_write, do_port;
	logic                 from_rom_c, ram_sel_c;
	logic [21:0]          rom_addr_c;
	logic [PAGE_BITS-1:0] slot_page;
	logic [PAGE_BITS-1:0] page_wr;

	assign quo_times_n = 17'(quo_s2) * 17'(RAM_BYTES);
	assign rem_full    = 17'(addr_s2) - quo_times_n;
	assign ram_idx     = rem_full[AW-1:0];

	assign is_ram   = (addr_s2 >= RAM_BASE);
	assign do_read  = advance && v_s2 && (cmd_s2 == CMD_MEM_READ);
	assign do_write = advance && v_s2 && (cmd_s2 == CMD_MEM_WRITE) && is_ram;
	assign do_port  = advance && v_s2 && (cmd_s2 == CMD_PORT_WR);
	assign page_wr  = PAGE_BITS'(data_s2 & bank_mask_q);

	always_comb begin
		case (addr_s2[15:14])
			SLOT_1:  slot_page = slot1_page_q;
			SLOT_2:  slot_page = slot2_page_q;
			default: slot_page = slot3_page_q;
		endcase
	end

	always_comb begin
		from_rom_c = 1'b0;
		ram_sel_c  = 1'b0;
		rom_addr_c = '0;
		if (cmd_s2 == CMD_MEM_READ) begin
			if (is_ram) begin
				ram_sel_c = 1'b1;
			end else begin
				from_rom_c = 1'b1;
				// fixed first kilobyte, or the whole low 8 KB in legacy mode
				if (addr_s2 < FIXED_LIMIT || (legacy_q && addr_s2 < LEGACY_LIMIT)) begin
					rom_addr_c = 22'(addr_s2);
				end else begin
					rom_addr_c = {8'(slot_page), addr_s2[13:0]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot1_page_q <= PAGE_BITS'(0);
			slot2_page_q <= PAGE_BITS'(1);
			slot3_page_q <= PAGE_BITS'(2);
			cart_ram_q   <= 1'b0;
		end else begin
			if (do_write) begin
				if (addr_s2 == CTRL_CART) begin
					cart_ram_q <= data_s2[3];
				end else if (addr_s2 == CTRL_SLOT1) begin
					slot1_page_q <= page_wr;
				end else if (addr_s2 == CTRL_SLOT2) begin
					slot2_page_q <= page_wr;
				end else if (addr_s2 == CTRL_SLOT3 && !cart_ram_q) begin
					// slot 3 page is locked while cart RAM is enabled
					slot3_page_q <= page_wr;
				end
			end
			if (do_port && addr_s2[7:0] == PORT_MAPPER && data_s2[3]) begin
				slot2_page_q <= PAGE_BITS'(2);
			end
		end
	end

	// Clearing pass after reset: zero one RAM entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(RAM_BYTES - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clr_active_q || do_write;
	assign ram_waddr = clr_active_q ? clr_idx_q : ram_idx;
	assign ram_wdata = clr_active_q ? 8'd0 : data_s2;
	assign ram_re    = do_read && is_ram;

	always_ff @(posedge clk) begin
		if (ram_we) begin
			work_ram[ram_waddr] <= ram_wdata;
		end
		if (ram_re) begin
			ram_rd_q <= work_ram[ram_idx];
		end
	end

	//------------------------------------------------------------------
	// Stage 3: response register
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (advance) begin
			from_rom_s3 <= from_rom_c;
			ram_sel_s3  <= ram_sel_c;
			rom_addr_s3 <= rom_addr_c;
		end
	end

	assign rsp.from_rom    = from_rom_s3;
	assign rsp.rom_address = rom_addr_s3;
	assign rsp.ram_data    = ram_sel_s3 ? ram_rd_q : 8'd0;

`ifndef ASSERT_OFF
	// No request may be in flight while the clearing pass owns the RAM
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !(v_s1 || v_s2 || v_s3))
		else $error("request in flight during RAM clearing pass");

	// Slot 3 page must hold for a cycle in which cart RAM is enabled
	a_slot3_lock: assert property (@(posedge clk) disable iff (!arst_n)
		cart_ram_q |=> $stable(slot3_page_q))
		else $error("slot 3 page changed while cart RAM enabled");

	// A response is either a ROM translation or a RAM read, never both
	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !(from_rom_s3 && ram_sel_s3))
		else $error("response selects both ROM and RAM");

	// RAM writes come only from the clearing pass or a memory write in stage 2
	a_ram_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (clr_active_q || (v_s2 && cmd_s2 == CMD_MEM_WRITE && is_ram)))
		else $error("unexpected work RAM write");
`endif

endmodule

`default_nettype wire

// File: tb/sv/console_bank_mapper_test.sv
// Self-checking testbench of the console bank mapper: directed and random CPU accesses.
`timescale 1ns / 1ps

module console_bank_mapper_test;
	import cbm_pkg::*;

	// The command value that the block leaves without effect
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int RAM_DEPTH    = 8192;
	localparam int CYCLE_LIMIT  = 200000;
	// Cycles to let pass after the last response before touching registers
	localparam int SETTLE_CYCLES = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	cbm_req_t    req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	cbm_rsp_t    rsp;

	console_bank_mapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Shadow copy of the mapper state, advanced at every accepted request
	logic [7:0] shadow_ram [RAM_DEPTH];
	logic [7:0] slot1_page;
	logic [7:0] slot2_page;
	logic [7:0] slot3_page;
	logic       cart_ram_on;
	logic [7:0] bank_mask;
	logic       legacy_mode;

	// Translations owed by the block, oldest first
	cbm_rsp_t pending_translations [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	// Idle rates in percent, and a long receiver hold-off counted by the stall process
	int src_idle_pct   = 0;
	int sink_idle_pct  = 0;
	int hold_cycles    = 0;

	// Translate one request and update the shadow state the way the mapper does.
	function automatic cbm_rsp_t map_access(input cbm_req_t r);
		cbm_rsp_t   e;
		logic [7:0] page;
		int         idx;
		e    = '0;
		page = r.data & bank_mask;
		idx  = int'(r.address) % RAM_DEPTH;
		case (r.command)
			CMD_MEM_READ: begin
				if (r.address >= RAM_BASE) begin
					e.ram_data = shadow_ram[idx];
				end else begin
					e.from_rom = 1'b1;
					// fixed first kilobyte, and the legacy window below 0x2000
					if (r.address < FIXED_LIMIT ||
						(legacy_mode && r.address < LEGACY_LIMIT)) begin
						e.rom_address = 22'(r.address);
					end else if (r.address[15:14] == SLOT_1) begin
						e.rom_address = {slot1_page, r.address[13:0]};
					end else if (r.address[15:14] == SLOT_2) begin
						e.rom_address = {slot2_page, r.address[13:0]};
					end else begin
						e.rom_address = {slot3_page, r.address[13:0]};
					end
				end
			end
			CMD_MEM_WRITE: begin
				// writes below the RAM window go to ROM and are dropped
				if (r.address >= RAM_BASE) begin
					shadow_ram[idx] = r.data;
					if (r.address == CTRL_CART) begin
						cart_ram_on = r.data[3];
					end else if (r.address == CTRL_SLOT1) begin
						slot1_page = page;
					end else if (r.address == CTRL_SLOT2) begin
						slot2_page = page;
					end else if (r.address == CTRL_SLOT3 && !cart_ram_on) begin
						slot3_page = page;
					end
				end
			end
			CMD_PORT_WR: begin
				if (r.address[7:0] == PORT_MAPPER && r.data[3]) begin
					slot2_page = 8'd2;
				end
			end
			default: begin
			end
		endcase
		return e;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endtask

	// Check every accepted response against the oldest owed translation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_translations.size() == 0) begin
				mismatch_count++;
				$display("%0t: response with none expected, got 0x%0h", $time, rsp);
			end else begin
				cbm_rsp_t want;
				want = pending_translations.pop_front();
				compare_field("from_rom", 32'(want.from_rom), 32'(rsp.from_rom));
				compare_field("rom_address", 32'(want.rom_address), 32'(rsp.rom_address));
				compare_field("ram_data", 32'(want.ram_data), 32'(rsp.ram_data));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles--;
		end else begin
			rsp_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one request, hold it until taken, then log its translation.
	// Entered and left at a falling edge; valid stays high for a following request.
	task automatic send_request(input logic [1:0] command, input logic [15:0] address,
			input logic [7:0] data);
		cbm_req_t r;
		r.command = command;
		r.address = address;
		r.data    = data;
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		pending_translations.push_back(map_access(r));
		@(negedge clk);
	endtask

	// Drop valid and wait for the pipeline to empty out.
	task automatic settle_pipeline();
		req_valid <= 1'b0;
		while (pending_translations.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_transfer(input logic write, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_config_readback();
		logic [31:0] value;
		apb_transfer(1'b0, {REG_BANK_MASK, 2'b00}, '0, value);
		compare_field("bank_mask readback", 32'(bank_mask), value);
		apb_transfer(1'b0, {REG_LEGACY, 2'b00}, '0, value);
		compare_field("legacy_mode readback", 32'(legacy_mode), value);
	endtask

	// Write both registers with junk in the unused bits, then read them back.
	task automatic set_mapping_config(input logic [7:0] mask, input logic legacy);
		logic [31:0] unused;
		settle_pipeline();
		apb_transfer(1'b1, {REG_BANK_MASK, 2'b00}, {24'($urandom), mask}, unused);
		bank_mask = mask;
		apb_transfer(1'b1, {REG_LEGACY, 2'b00}, {31'($urandom), legacy}, unused);
		legacy_mode = legacy;
		check_config_readback();
	endtask

	// Mostly well-formed traffic: reads over the map, control and RAM writes,
	// mapper port hits, with some stray writes, other ports and the unused command.
	task automatic send_random_request();
		int unsigned pick;
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  data;
		pick    = $urandom_range(99);
		address = 16'($urandom);
		data    = 8'($urandom);
		if (pick < 50) begin
			command = CMD_MEM_READ;
			// bias some reads into the fixed and legacy windows
			if (pick < 10) address = 16'($urandom_range(16'h2FFF));
		end else if (pick < 80) begin
			command = CMD_MEM_WRITE;
			if (pick < 62) begin
				address = CTRL_CART + 16'($urandom_range(3));
			end else if (pick < 75) begin
				address[15:14] = 2'b11;
			end
		end else if (pick < 96) begin
			command = CMD_PORT_WR;
			if (pick < 90) address[7:0] = PORT_MAPPER;
		end else begin
			command = CMD_UNUSED;
		end
		send_request(command, address, data);
	endtask

	// Reset state: register defaults and the default page layout 0/1/2.
	task automatic test_reset_map();
		check_config_readback();
		send_request(CMD_MEM_READ, 16'h0000, 8'hFF);
		send_request(CMD_MEM_READ, 16'h03FF, 8'h00);
		send_request(CMD_MEM_READ, 16'h0400, 8'h5A);
		send_request(CMD_MEM_READ, 16'h7FFF, 8'hA5);
		send_request(CMD_MEM_READ, 16'hBFFF, 8'hFF);
		send_request(CMD_MEM_READ, 16'hC000, 8'h00);
	endtask

	// Work RAM mirrored over the upper quarter
	task automatic test_ram_mirror();
		send_request(CMD_MEM_WRITE, 16'hDFFF, 8'hA5);
		send_request(CMD_MEM_READ, 16'hFFFF, 8'h00);
	endtask

	// Page writes through the mask, then reads of all three slots
	task automatic test_page_registers();
		send_request(CMD_MEM_WRITE, CTRL_SLOT1, 8'hFF);
		send_request(CMD_MEM_WRITE, CTRL_SLOT2, 8'h03);
		send_request(CMD_MEM_WRITE, CTRL_SLOT3, 8'h05);
		send_request(CMD_MEM_READ, 16'h3FFF, 8'h00);
		send_request(CMD_MEM_READ, 16'h4000, 8'h00);
		send_request(CMD_MEM_READ, 16'h8000, 8'h00);
	endtask

	// Slot 3 page frozen while cart RAM is enabled; reads still use it
	task automatic test_cart_ram_flag();
		send_request(CMD_MEM_WRITE, CTRL_CART, 8'h08);
		send_request(CMD_MEM_WRITE, CTRL_SLOT3, 8'h07);
		send_request(CMD_MEM_READ, 16'h8001, 8'h00);
		send_request(CMD_MEM_WRITE, CTRL_CART, 8'hF7);
	endtask

	// Mapper port forces slot 2 to page 2; other ports do nothing
	task automatic test_mapper_port();
		send_request(CMD_PORT_WR, {8'h01, PORT_MAPPER}, 8'h08);
		send_request(CMD_PORT_WR, 16'hFF3F, 8'hFF);
		send_request(CMD_MEM_READ, 16'h4000, 8'h00);
	endtask

	// The unused command value changes nothing, even aimed at a control byte
	task automatic test_unused_command();
		send_request(CMD_UNUSED, CTRL_SLOT3, 8'hFF);
		send_request(CMD_MEM_READ, 16'hBFFF, 8'h00);
	endtask

	// Legacy window with the widest mask
	task automatic test_legacy_reads();
		set_mapping_config(8'hFF, 1'b1);
		send_request(CMD_MEM_WRITE, CTRL_SLOT1, 8'hFF);
		send_request(CMD_MEM_READ, 16'h1FFF, 8'h00);
		send_request(CMD_MEM_READ, 16'h2000, 8'h00);
	endtask

	task automatic run_random_phase(input int count, input logic [7:0] mask,
			input logic legacy, input int src_pct, input int sink_pct);
		set_mapping_config(mask, legacy);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (count) send_random_request();
	endtask

	// Random traffic over several register settings and idle profiles
	task automatic test_random_traffic();
		run_random_phase(300, BANK_MASK_RST, 1'b0, 16, 60);
		run_random_phase(300, 8'hFF, 1'b1, 60, 16);
		run_random_phase(200, 8'h00, 1'b0, 0, 0);
		run_random_phase(250, 8'($urandom), 1'($urandom), 0, 0);
	endtask

	// Hold the receiver off for a long stretch while requests keep coming,
	// so the pipeline fills and the block stalls its input.
	task automatic test_back_pressure();
		set_mapping_config(8'h0F, 1'b0);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_cycles   = 150;
		repeat (80) send_random_request();
	endtask

	initial begin
		slot1_page  = 8'd0;
		slot2_page  = 8'd1;
		slot3_page  = 8'd2;
		cart_ram_on = 1'b0;
		bank_mask   = BANK_MASK_RST;
		legacy_mode = 1'b0;
		foreach (shadow_ram[i]) shadow_ram[i] = 8'h00;

		// Hold reset, then release it on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed checks run under the first idle profile
		src_idle_pct  = 16;
		sink_idle_pct = 60;
		test_reset_map();
		test_ram_mirror();
		test_page_registers();
		test_cart_ram_flag();
		test_mapper_port();
		test_unused_command();
		test_legacy_reads();
		test_random_traffic();
		test_back_pressure();

		// Drain everything owed, then wait on for stray responses
		settle_pipeline();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
